### rtl/tcf_pkg.sv
// Package for the typed constant fold ALU.
// Kind and operation codes, and the sideband record carried down the divider.
package tcf_pkg;

  localparam logic [2:0] KIND_S = 3'd0;
  localparam logic [2:0] KIND_U = 3'd1;
  localparam logic [2:0] KIND_D = 3'd2;
  localparam logic [2:0] KIND_F = 3'd3;
  localparam logic [2:0] KIND_P = 3'd4;

  localparam logic [4:0] MODE_PLUS  = 5'd0;
  localparam logic [4:0] MODE_MINUS = 5'd1;
  localparam logic [4:0] MODE_LNOT  = 5'd2;
  localparam logic [4:0] MODE_CPL   = 5'd3;
  localparam logic [4:0] MODE_ADD   = 5'd4;
  localparam logic [4:0] MODE_SUB   = 5'd5;
  localparam logic [4:0] MODE_MUL   = 5'd6;
  localparam logic [4:0] MODE_DIV   = 5'd7;
  localparam logic [4:0] MODE_MOD   = 5'd8;
  localparam logic [4:0] MODE_SHL   = 5'd9;
  localparam logic [4:0] MODE_SHR   = 5'd10;
  localparam logic [4:0] MODE_AND   = 5'd11;
  localparam logic [4:0] MODE_OR    = 5'd12;
  localparam logic [4:0] MODE_XOR   = 5'd13;
  localparam logic [4:0] MODE_EQ    = 5'd14;
  localparam logic [4:0] MODE_NE    = 5'd15;
  localparam logic [4:0] MODE_LT    = 5'd16;
  localparam logic [4:0] MODE_LE    = 5'd17;
  localparam logic [4:0] MODE_GT    = 5'd18;
  localparam logic [4:0] MODE_GE    = 5'd19;
  localparam logic [4:0] MODE_LAND  = 5'd20;
  localparam logic [4:0] MODE_LOR   = 5'd21;
  localparam logic [4:0] MODE_SEL   = 5'd22;

  localparam int unsigned DW = 64;

  typedef struct packed {
    logic          kind;
    logic          is_div;
    logic          is_mod;
    logic          neg_q;
    logic          err;
    logic [2:0]    rkind;
    logic [DW-1:0] value;
  } side_t;

endpackage

### rtl/tcf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tcf_pkg; carries an side_t record alongside each transfer.
module tcf_div import tcf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  side_t         side_i,
  output logic          vld_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o,
  output side_t         side_o
);

  logic          vld_q [DW+1];
  logic [DW-1:0] rem_q [DW+1];
  logic [DW-1:0] dq_q  [DW+1];
  logic [DW-1:0] dv_q  [DW+1];
  side_t         sd_q  [DW+1];

  assign vld_q[0] = vld_i;
  assign rem_q[0] = '0;
  assign dq_q[0]  = dividend_i;
  assign dv_q[0]  = divisor_i;
  assign sd_q[0]  = side_i;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;
    assign trial = {rem_q[i], dq_q[i][DW-1]};
    assign diff  = trial - {1'b0, dv_q[i]};
    assign take  = !diff[DW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
      dq_q[i+1]  <= {dq_q[i][DW-2:0], take};
      dv_q[i+1]  <= dv_q[i];
      sd_q[i+1]  <= sd_q[i];
    end
  end

  assign vld_o  = vld_q[DW];
  assign quo_o  = dq_q[DW];
  assign rem_o  = rem_q[DW];
  assign side_o = sd_q[DW];

endmodule

### rtl/typed_constant_fold_alu.sv
// Top level of the typed constant fold ALU.
// Depends on tcf_pkg and tcf_div.
//
//  channel  | handshake        | fields
//  command  | start_i, busy_o  | mode_i, left/right/third kind_i and value_i
//  result   | valid_o strobe   | result_kind_o, result_value_o, error_o
//
// One item may enter every cycle; busy_o stays low.
// Pipeline: input register, decode, multiply sum,
// 64 divider stages (one quotient bit each), output register.
// Reset clears the valid bits only. The receiver cannot stall.
module typed_constant_fold_alu import tcf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [4:0]    mode_i,
  input  logic [2:0]    left_kind_i,
  input  logic [63:0]   left_value_i,
  input  logic [2:0]    right_kind_i,
  input  logic [63:0]   right_value_i,
  input  logic [2:0]    third_kind_i,
  input  logic [63:0]   third_value_i,
  output logic          valid_o,
  output logic [2:0]    result_kind_o,
  output logic [63:0]   result_value_o,
  output logic          error_o
);

  assign busy_o = 1'b0;

  logic        a_vld_q;
  logic [4:0]  a_mode_q;
  logic [2:0]  a_lk_q, a_rk_q, a_tk_q;
  logic [63:0] a_lv_q, a_rv_q, a_tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_mode_q <= mode_i;
    a_lk_q   <= left_kind_i;
    a_lv_q   <= left_value_i;
    a_rk_q   <= right_kind_i;
    a_rv_q   <= right_value_i;
    a_tk_q   <= third_kind_i;
    a_tv_q   <= third_value_i;
  end

  logic        uns, l_int, r_int, l_bool, r_bool, big_sh, lt, gt, cond, rel;
  logic [2:0]  ck;
  logic [63:0] cv;
  side_t       b_side_d;
  logic [63:0] dvd_d, dvs_d;

  always_comb begin
    uns    = (a_lk_q == KIND_U) || (a_rk_q == KIND_U);
    l_int  = (a_lk_q == KIND_S) || (a_lk_q == KIND_U);
    r_int  = (a_rk_q == KIND_S) || (a_rk_q == KIND_U);
    l_bool = l_int || (a_lk_q == KIND_P);
    r_bool = r_int || (a_rk_q == KIND_P);
    big_sh = |a_rv_q[63:6];
    lt     = uns ? (a_lv_q < a_rv_q) : ($signed(a_lv_q) < $signed(a_rv_q));
    gt     = uns ? (a_rv_q < a_lv_q) : ($signed(a_rv_q) < $signed(a_lv_q));
    cond   = |a_lv_q;
    ck     = cond ? a_rk_q : a_tk_q;
    cv     = cond ? a_rv_q : a_tv_q;
    rel    = 1'b0;
    b_side_d       = '0;
    b_side_d.rkind = uns ? KIND_U : KIND_S;
    dvd_d = a_lv_q;
    dvs_d = a_rv_q;
    unique case (a_mode_q) inside
      MODE_PLUS: begin
        b_side_d.rkind = a_lk_q;
        b_side_d.value = (a_lk_q == KIND_F) ? {32'b0, a_lv_q[31:0]} : a_lv_q;
        b_side_d.err   = a_lk_q > KIND_P;
      end
      MODE_MINUS: begin
        b_side_d.rkind = a_lk_q;
        if (l_int) b_side_d.value = -a_lv_q;
        else if (a_lk_q == KIND_D) b_side_d.value = {~a_lv_q[63], a_lv_q[62:0]};
        else if (a_lk_q == KIND_F) b_side_d.value = {32'b0, ~a_lv_q[31], a_lv_q[30:0]};
        else b_side_d.err = 1'b1;
      end
      MODE_LNOT: begin
        b_side_d.rkind = KIND_S;
        b_side_d.value = {63'b0, !cond};
        b_side_d.err   = !l_bool;
      end
      MODE_CPL: begin
        b_side_d.rkind = KIND_U;
        b_side_d.value = ~a_lv_q;
        b_side_d.err   = !l_int;
      end
      MODE_SHL, MODE_SHR: begin
        b_side_d.rkind = a_lk_q;
        b_side_d.err   = !(l_int && r_int);
        if (a_mode_q == MODE_SHL) begin
          b_side_d.value = big_sh ? '0 : (a_lv_q << a_rv_q[5:0]);
        end else if (a_lk_q == KIND_S && a_lv_q[63]) begin
          b_side_d.value = big_sh ? '1 : 64'($signed(a_lv_q) >>> a_rv_q[5:0]);
        end else begin
          b_side_d.value = big_sh ? '0 : (a_lv_q >> a_rv_q[5:0]);
        end
      end
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_AND, MODE_OR, MODE_XOR: begin
        b_side_d.err = !(l_int && r_int);
        case (a_mode_q)
          MODE_ADD: b_side_d.value = a_lv_q + a_rv_q;
          MODE_SUB: b_side_d.value = a_lv_q - a_rv_q;
          MODE_AND: b_side_d.value = a_lv_q & a_rv_q;
          MODE_OR:  b_side_d.value = a_lv_q | a_rv_q;
          MODE_XOR: b_side_d.value = a_lv_q ^ a_rv_q;
          default:  b_side_d.value = '0;
        endcase
      end
      MODE_DIV: begin
        b_side_d.err    = !(l_int && r_int) || (a_rv_q == '0);
        b_side_d.is_div = 1'b1;
        if (!uns) begin
          dvd_d = a_lv_q[63] ? -a_lv_q : a_lv_q;
          dvs_d = a_rv_q[63] ? -a_rv_q : a_rv_q;
          b_side_d.neg_q = a_lv_q[63] ^ a_rv_q[63];
        end
      end
      MODE_MOD: begin
        b_side_d.err    = !(l_int && r_int) || (a_rv_q == '0);
        b_side_d.is_mod = 1'b1;
        b_side_d.rkind  = KIND_U;
      end
      MODE_EQ, MODE_NE, MODE_LT, MODE_LE, MODE_GT, MODE_GE: begin
        b_side_d.err   = !(l_int && r_int);
        b_side_d.rkind = KIND_S;
        case (a_mode_q)
          MODE_EQ: rel = a_lv_q == a_rv_q;
          MODE_NE: rel = a_lv_q != a_rv_q;
          MODE_LT: rel = lt;
          MODE_LE: rel = !gt;
          MODE_GT: rel = gt;
          default: rel = !lt;
        endcase
        b_side_d.value = {63'b0, rel};
      end
      MODE_LAND, MODE_LOR: begin
        b_side_d.err   = !(l_bool && r_bool);
        b_side_d.rkind = KIND_S;
        b_side_d.value = {63'b0, (a_mode_q == MODE_LAND) ? (cond && (|a_rv_q))
                                                         : (cond || (|a_rv_q))};
      end
      MODE_SEL: begin
        b_side_d.err   = !l_bool || (ck > KIND_P);
        b_side_d.rkind = ck;
        b_side_d.value = (ck == KIND_F) ? {32'b0, cv[31:0]} : cv;
      end
      default: b_side_d.err = 1'b1;
    endcase
    b_side_d.kind = (a_mode_q == MODE_MUL);
  end

  logic        b_vld_q;
  side_t       b_side_q;
  logic [63:0] b_dvd_q, b_dvs_q, b_p0_q;
  logic [31:0] b_p1_q, b_p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_side_q <= b_side_d;
    b_dvd_q  <= dvd_d;
    b_dvs_q  <= dvs_d;
    b_p0_q   <= a_lv_q[31:0] * a_rv_q[31:0];
    b_p1_q   <= 32'(a_lv_q[31:0] * a_rv_q[63:32]);
    b_p2_q   <= 32'(a_lv_q[63:32] * a_rv_q[31:0]);
  end

  logic        c_vld_q;
  side_t       c_side_q;
  logic [63:0] c_dvd_q, c_dvs_q;
  side_t       c_side_d;

  always_comb begin
    c_side_d = b_side_q;
    if (b_side_q.kind) c_side_d.value = b_p0_q + {b_p1_q + b_p2_q, 32'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_side_q <= c_side_d;
    c_dvd_q  <= b_dvd_q;
    c_dvs_q  <= b_dvs_q;
  end

  logic        d_vld;
  logic [63:0] d_quo, d_rem;
  side_t       d_side;

  tcf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (c_vld_q),
    .dividend_i (c_dvd_q),
    .divisor_i  (c_dvs_q),
    .side_i     (c_side_q),
    .vld_o      (d_vld),
    .quo_o      (d_quo),
    .rem_o      (d_rem),
    .side_o     (d_side)
  );

  logic        out_vld_q, out_err_q;
  logic [2:0]  out_kind_q;
  logic [63:0] out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_err_q  <= d_side.err;
    out_kind_q <= d_side.err ? KIND_S : d_side.rkind;
    if (d_side.err)         out_val_q <= '0;
    else if (d_side.is_div) out_val_q <= d_side.neg_q ? -d_quo : d_quo;
    else if (d_side.is_mod) out_val_q <= d_rem;
    else                    out_val_q <= d_side.value;
  end

  assign valid_o        = out_vld_q;
  assign result_kind_o  = out_kind_q;
  assign result_value_o = out_val_q;
  assign error_o        = out_err_q;

endmodule

### sim/tb_typed_constant_fold_alu.sv
// Self-checking testbench for typed_constant_fold_alu.
// Drives typed fold commands, predicts each result in a scoreboard class and
// compares it with the strobed output. Depends on tcf_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_typed_constant_fold_alu;
  import tcf_pkg::*;

  localparam int LATENCY = 68;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] value;
    logic        err;
  } fold_res_t;

  class fold_board;
    fold_res_t pending[$];
    int        mismatches;
    int        checked;

    function logic [63:0] single_bits(logic [2:0] k, logic [63:0] v);
      return (k == KIND_F) ? {32'd0, v[31:0]} : v;
    endfunction

    function void note_command(logic [4:0] md, logic [2:0] lk, logic [63:0] lv,
                               logic [2:0] rk, logic [63:0] rv,
                               logic [2:0] tk, logic [63:0] tv);
      fold_res_t r;
      logic       lint, rint, lbool, rbool, uns, lt, gt, bit_r;
      logic [2:0]  ck;
      logic [63:0] cv, ma, mb, q;
      r.kind = KIND_S;
      r.value = '0;
      r.err = 1'b0;
      lint = (lk == KIND_S) || (lk == KIND_U);
      rint = (rk == KIND_S) || (rk == KIND_U);
      lbool = lint || (lk == KIND_P);
      rbool = rint || (rk == KIND_P);
      uns = (lk == KIND_U) || (rk == KIND_U);
      case (md) inside
        MODE_PLUS:
          if (lk <= KIND_P) begin
            r.kind = lk; r.value = single_bits(lk, lv);
          end else r.err = 1'b1;
        MODE_MINUS:
          if (lint) begin
            r.kind = lk; r.value = -lv;
          end else if (lk == KIND_D) begin
            r.kind = lk; r.value = lv ^ 64'h8000_0000_0000_0000;
          end else if (lk == KIND_F) begin
            r.kind = lk; r.value = {32'd0, lv[31:0] ^ 32'h8000_0000};
          end else r.err = 1'b1;
        MODE_LNOT:
          if (lbool) r.value = {63'd0, lv == 0}; else r.err = 1'b1;
        MODE_CPL:
          if (lint) begin
            r.kind = KIND_U; r.value = ~lv;
          end else r.err = 1'b1;
        MODE_SHL, MODE_SHR:
          if (!(lint && rint)) r.err = 1'b1;
          else begin
            r.kind = lk;
            if (md == MODE_SHL) r.value = (rv >= 64) ? '0 : lv << rv[5:0];
            else if (lk == KIND_S && lv[63])
              r.value = (rv >= 64) ? '1 : ~((~lv) >> rv[5:0]);
            else r.value = (rv >= 64) ? '0 : lv >> rv[5:0];
          end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_AND, MODE_OR,
        MODE_XOR, MODE_EQ, MODE_NE, MODE_LT, MODE_LE, MODE_GT, MODE_GE:
          if (!(lint && rint)) r.err = 1'b1;
          else begin
            r.kind = uns ? KIND_U : KIND_S;
            lt = uns ? (lv < rv) : ($signed(lv) < $signed(rv));
            gt = uns ? (rv < lv) : ($signed(rv) < $signed(lv));
            case (md)
              MODE_ADD: r.value = lv + rv;
              MODE_SUB: r.value = lv - rv;
              MODE_MUL: r.value = lv * rv;
              MODE_DIV:
                if (rv == 0) r.err = 1'b1;
                else if (uns) r.value = lv / rv;
                else begin
                  ma = lv[63] ? -lv : lv;
                  mb = rv[63] ? -rv : rv;
                  q = ma / mb;
                  r.value = (lv[63] != rv[63]) ? -q : q;
                end
              MODE_MOD:
                if (rv == 0) r.err = 1'b1;
                else begin
                  r.kind = KIND_U; r.value = lv % rv;
                end
              MODE_AND: r.value = lv & rv;
              MODE_OR:  r.value = lv | rv;
              MODE_XOR: r.value = lv ^ rv;
              default: begin
                r.kind = KIND_S;
                case (md)
                  MODE_EQ: bit_r = (lv == rv);
                  MODE_NE: bit_r = (lv != rv);
                  MODE_LT: bit_r = lt;
                  MODE_LE: bit_r = !gt;
                  MODE_GT: bit_r = gt;
                  default: bit_r = !lt;
                endcase
                r.value = {63'd0, bit_r};
              end
            endcase
          end
        MODE_LAND, MODE_LOR:
          if (!(lbool && rbool)) r.err = 1'b1;
          else r.value = {63'd0, (md == MODE_LAND) ? ((lv != 0) && (rv != 0))
                                                   : ((lv != 0) || (rv != 0))};
        MODE_SEL:
          if (!lbool) r.err = 1'b1;
          else begin
            ck = (lv != 0) ? rk : tk;
            cv = (lv != 0) ? rv : tv;
            if (ck <= KIND_P) begin
              r.kind = ck; r.value = single_bits(ck, cv);
            end else r.err = 1'b1;
          end
        default: r.err = 1'b1;
      endcase
      if (r.err) begin
        r.kind = KIND_S; r.value = '0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] k, logic [63:0] v, logic e);
      fold_res_t x;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind=%0d value=%h err=%b", k, v, e);
        return;
      end
      x = pending.pop_front();
      if (k !== x.kind || v !== x.value || e !== x.err) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind=%0d value=%h err=%b, got kind=%0d value=%h err=%b",
                   x.kind, x.value, x.err, k, v, e);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [4:0]  mode_i = '0;
  logic [2:0]  left_kind_i = '0, right_kind_i = '0, third_kind_i = '0;
  logic [63:0] left_value_i = '0, right_value_i = '0, third_value_i = '0;
  logic        valid_o;
  logic [2:0]  result_kind_o;
  logic [63:0] result_value_o;
  logic        error_o;

  fold_board board = new();
  int        commands;

  typed_constant_fold_alu uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) board.check_result(result_kind_o, result_value_o, error_o);
    if (rst_ni && start_i && !busy_o) begin
      board.note_command(mode_i, left_kind_i, left_value_i, right_kind_i, right_value_i,
                         third_kind_i, third_value_i);
      commands++;
    end
  end

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      5: return 64'($urandom_range(0, 80));
      6: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [2:0] pick_kind();
    return ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1))
                                      : 3'($urandom_range(0, 7));
  endfunction

  task automatic send(logic [4:0] md, logic [2:0] lk, logic [63:0] lv,
                      logic [2:0] rk, logic [63:0] rv,
                      logic [2:0] tk, logic [63:0] tv, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= md;
    left_kind_i <= lk; left_value_i <= lv;
    right_kind_i <= rk; right_value_i <= rv;
    third_kind_i <= tk; third_value_i <= tv;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic send_random(int gap);
    logic [4:0] md;
    md = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(23, 31)) : 5'($urandom_range(0, 22));
    send(md, pick_kind(), pick_value(), pick_kind(), pick_value(),
         3'($urandom_range(0, 7)), pick_value(), gap);
  endtask

  initial begin
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
    int burst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(MODE_PLUS, KIND_F, '1, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_PLUS, 3'd5, 1, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_MINUS, KIND_D, 64'h3ff0_0000_0000_0000, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_MINUS, KIND_F, 64'hffff_ffff_3f80_0000, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_MINUS, KIND_P, 1, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_LNOT, KIND_P, 0, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_CPL, KIND_S, MINV, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_DIV, KIND_S, MINV, KIND_S, '1, KIND_S, 0, 0);
    send(MODE_DIV, KIND_S, 64'hffff_ffff_ffff_fff9, KIND_S, 2, KIND_S, 0, 0);
    send(MODE_DIV, KIND_U, 7, KIND_U, 0, KIND_S, 0, 0);
    send(MODE_MOD, KIND_S, 64'hffff_ffff_ffff_fff9, KIND_S, 3, KIND_S, 0, 0);
    send(MODE_MOD, KIND_S, 5, KIND_S, 0, KIND_S, 0, 0);
    send(MODE_SHL, KIND_S, '1, KIND_U, 64, KIND_S, 0, 0);
    send(MODE_SHR, KIND_S, MINV, KIND_S, 63, KIND_S, 0, 0);
    send(MODE_SHR, KIND_S, MINV, KIND_S, 100, KIND_S, 0, 0);
    send(MODE_SHR, KIND_U, MINV, KIND_S, 64, KIND_S, 0, 0);
    send(MODE_LT, KIND_S, MINV, KIND_S, 1, KIND_S, 0, 0);
    send(MODE_LT, KIND_U, MINV, KIND_S, 1, KIND_S, 0, 0);
    send(MODE_ADD, KIND_D, 1, KIND_S, 1, KIND_S, 0, 0);
    send(MODE_LAND, KIND_P, 2, KIND_U, 1, KIND_S, 0, 0);
    send(MODE_LOR, KIND_F, 0, KIND_S, 1, KIND_S, 0, 0);
    send(MODE_SEL, KIND_S, 1, KIND_F, '1, 3'd7, 0, 0);
    send(MODE_SEL, KIND_S, 0, 3'd6, 0, KIND_D, '1, 0);
    send(MODE_SEL, KIND_D, 1, KIND_S, 0, KIND_S, 0, 0);
    send(5'd31, KIND_S, 0, KIND_S, 0, KIND_S, 0, 0);
    for (int m = 0; m < 32; m++) send(5'(m), pick_kind(), pick_value(), pick_kind(),
                                      pick_value(), pick_kind(), pick_value(), 0);
    for (int i = 0; i < 1650; i++) begin
      if (i == 800) begin
        start_i <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk_i);
      end
      burst = (i % 200) < 60;
      send_random(burst ? 0 : $urandom_range(0, 3));
    end
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Ran %0d fold commands over all operations, kinds and error cases;", commands);
    $display("checked %0d results, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
